[design/okr_pkg.sv]
// ----------------------------------------------------------------------------
// okr_pkg
// Shared types and constants of the offset keyed random byte reader.
// ----------------------------------------------------------------------------
package okr_pkg;

    localparam int LEN_W     = 9;
    localparam int MAX_LEN   = 256;
    localparam int OFFSET_W  = 64;
    localparam int WADDR_W   = 62;
    localparam int COUNT_W   = 4;
    localparam int DATA_W    = 64;

    localparam logic [31:0] KEY_LO0 = 32'hb37916a5;
    localparam logic [31:0] KEY_LO1 = 32'h2e714eb2;
    localparam logic [31:0] KEY_HI0 = 32'hb500f16e;
    localparam logic [31:0] KEY_HI1 = 32'h12e15e35;
    localparam logic [63:0] KEY_LO  = {KEY_LO1, KEY_LO0};

    typedef struct packed {
        logic [WADDR_W-1:0] waddr;
        logic [2:0]         skip;
        logic [COUNT_W-1:0] count;
        logic               last;
    } beat_desc_t;

endpackage

[design/okr_front.sv]
// ----------------------------------------------------------------------------
// okr_front
// Takes a request and splits it into word-aligned beat descriptors.
// ----------------------------------------------------------------------------
module okr_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [okr_pkg::OFFSET_W-1:0] start_offset,
    input  logic [okr_pkg::LEN_W-1:0]  byte_length,
    output logic                       push,
    output okr_pkg::beat_desc_t        push_desc,
    input  logic                       queue_full
);
    import okr_pkg::*;

    logic               busy_reg;
    logic               busy_next;
    logic [WADDR_W-1:0] waddr_reg;
    logic [WADDR_W-1:0] waddr_next;
    logic [2:0]         skip_reg;
    logic [2:0]         skip_next;
    logic [LEN_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   rem_next;
    logic [COUNT_W-1:0] count_room;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               accept;
    logic [LEN_W-1:0]   len_sat;

    assign count_room = COUNT_W'(8) - {1'b0, skip_reg};
    assign count      = (rem_reg < LEN_W'(count_room)) ? rem_reg[COUNT_W-1:0] : count_room;
    assign last       = (rem_reg == LEN_W'(count));
    assign push       = busy_reg && !queue_full;
    assign req_ready  = !busy_reg || (push && last);
    assign accept     = req_valid && req_ready;
    assign len_sat    = (int'(byte_length) > MAX_LEN) ? LEN_W'(MAX_LEN) : byte_length;

    assign push_desc.waddr = waddr_reg;
    assign push_desc.skip  = skip_reg;
    assign push_desc.count = count;
    assign push_desc.last  = last;

    always_comb
    begin
        busy_next  = busy_reg;
        waddr_next = waddr_reg;
        skip_next  = skip_reg;
        rem_next   = rem_reg;
        if (push)
        begin
            busy_next  = !last;
            waddr_next = waddr_reg + WADDR_W'(1);
            skip_next  = 3'd0;
            rem_next   = rem_reg - LEN_W'(count);
        end
        if (accept)
        begin
            busy_next  = 1'b1;
            waddr_next = {1'b0, start_offset[OFFSET_W-1:3]};
            skip_next  = start_offset[2:0];
            rem_next   = len_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            waddr_reg <= '0;
            skip_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            waddr_reg <= waddr_next;
            skip_reg  <= skip_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

[design/okr_queue.sv]
// ----------------------------------------------------------------------------
// okr_queue
// Short descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
module okr_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  okr_pkg::beat_desc_t push_desc,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output okr_pkg::beat_desc_t pop_desc
);
    import okr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    beat_desc_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_desc  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[design/okr_back.sv]
// ----------------------------------------------------------------------------
// okr_back
// Word hash pipeline: partial products, sums, then byte select into the
// output register.
// ----------------------------------------------------------------------------
module okr_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      desc_valid,
    input  okr_pkg::beat_desc_t       desc,
    output logic                      desc_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [okr_pkg::DATA_W-1:0]  out_data,
    output logic [okr_pkg::COUNT_W-1:0] out_count,
    output logic                      out_last
);
    import okr_pkg::*;

    logic               advance;
    logic [63:0]        lo;

    logic               s1_valid_reg;
    beat_desc_t         s1_desc_reg;
    logic [63:0]        p00_reg;
    logic [63:0]        p01_reg;
    logic [63:0]        p10_reg;
    logic [63:0]        p11_reg;
    logic [63:0]        q00_reg;
    logic [31:0]        q01_reg;
    logic [31:0]        q10_reg;

    logic               s2_valid_reg;
    beat_desc_t         s2_desc_reg;
    logic [33:0]        mid_reg;
    logic [63:0]        hsum_reg;
    logic [63:0]        lsum_reg;
    logic [33:0]        mid_next;
    logic [63:0]        hsum_next;
    logic [63:0]        lsum_next;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;
    logic [63:0]        word;
    logic [63:0]        shifted;
    logic [63:0]        mask;

    assign advance  = !out_valid_reg || out_ready;
    assign desc_pop = advance && desc_valid;
    assign lo       = {desc.waddr[WADDR_W-2:0], 3'b000};

    // high half of lo * key_lo, low half of lo * key_hi, carry of position bit 64
    assign mid_next  = 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
    assign hsum_next = p11_reg + 64'(p01_reg[63:32]) + 64'(p10_reg[63:32]);
    assign lsum_next = q00_reg + {q01_reg + q10_reg, 32'h0}
                     + (s1_desc_reg.waddr[WADDR_W-1] ? KEY_LO : 64'h0);

    assign word    = hsum_reg + lsum_reg + 64'(mid_reg[33:32]);
    assign shifted = word >> {s2_desc_reg.skip, 3'b000};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mask[8*i +: 8] = (COUNT_W'(i) < s2_desc_reg.count) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= desc_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_desc_reg   <= desc;
            p00_reg       <= lo[31:0] * KEY_LO0;
            p01_reg       <= lo[31:0] * KEY_LO1;
            p10_reg       <= lo[63:32] * KEY_LO0;
            p11_reg       <= lo[63:32] * KEY_LO1;
            q00_reg       <= lo[31:0] * KEY_HI0;
            q01_reg       <= 32'(lo[31:0] * KEY_HI1);
            q10_reg       <= 32'(lo[63:32] * KEY_HI0);
            s2_desc_reg   <= s1_desc_reg;
            mid_reg       <= mid_next;
            hsum_reg      <= hsum_next;
            lsum_reg      <= lsum_next;
            out_data_reg  <= shifted & mask;
            out_count_reg <= s2_desc_reg.count;
            out_last_reg  <= s2_desc_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

[design/offset_keyed_random_byte_reader.sv]
// ----------------------------------------------------------------------------
// offset_keyed_random_byte_reader
// Serves byte ranges of a virtual file of keyed pseudo-random words.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: start offset and byte length (length above
//   256 saturates). m_axis returns the bytes in beats that never cross an
//   8-byte word boundary, packed from bit 0, with a byte count and tlast on
//   the final beat. a zero-length request gives one empty beat with tlast.
//   the front splits a request into beat descriptors, one per cycle while
//   the queue has room, into a short queue; the back runs a three-stage
//   multiply pipeline per word. a taken request is registered in the
//   front, and each word passes the queue and the back's product, sum and
//   output registers; beats leave one per cycle while m_axis_tready is
//   high. the next request is taken in the cycle the front issues the last
//   descriptor of the current one. when m_axis_tready is low the back
//   pipeline holds, the queue fills and the front stops; nothing is dropped.
//   reset empties the queue and pipeline and leaves the block idle.
// ----------------------------------------------------------------------------
module offset_keyed_random_byte_reader
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // start_offset[63:0], byte_length[72:64], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // data[63:0], byte_count[67:64], zero pad
    output logic        m_axis_tlast
);
    import okr_pkg::*;

    logic               push;
    beat_desc_t         push_desc;
    logic               queue_full;
    logic               pop;
    logic               not_empty;
    beat_desc_t         pop_desc;
    logic [DATA_W-1:0]  out_data;
    logic [COUNT_W-1:0] out_count;

    okr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_axis_tvalid),
        .req_ready    (s_axis_tready),
        .start_offset (s_axis_tdata[63:0]),
        .byte_length  (s_axis_tdata[72:64]),
        .push         (push),
        .push_desc    (push_desc),
        .queue_full   (queue_full)
    );

    okr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_desc  (pop_desc)
    );

    okr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (not_empty),
        .desc       (pop_desc),
        .desc_pop   (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data),
        .out_count  (out_count),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_count, out_data};

endmodule
